[rtl/hpc_pkg.sv]
// Shared types and constants of the hopping phase controller.
package hpc_pkg;

   // Phase codes as they appear on the result channel.
   localparam logic [2:0] PH_LOADING     = 3'd0;
   localparam logic [2:0] PH_COMPRESSION = 3'd1;
   localparam logic [2:0] PH_THRUST      = 3'd2;
   localparam logic [2:0] PH_UNLOADING   = 3'd3;
   localparam logic [2:0] PH_FLIGHT      = 3'd4;

   // Torque mode codes.
   localparam logic [1:0] MODE_ZERO     = 2'd0;
   localparam logic [1:0] MODE_ATTITUDE = 2'd1;
   localparam logic [1:0] MODE_FLIGHT   = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_REST_LENGTH      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCH_LENGTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRING_STIFFNESS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRUST_FORCE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_KP          = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_KV          = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_MS          = 3'd6;

   // Reset values of the configuration registers.
   localparam logic [15:0] RST_REST_LENGTH      = 16'd16384;
   localparam logic [15:0] RST_SWITCH_LENGTH    = 16'd14746;
   localparam logic [15:0] RST_SPRING_STIFFNESS = 16'd2500;
   localparam logic [19:0] RST_THRUST_FORCE     = 20'd51200;
   localparam logic [15:0] RST_POSE_KP          = 16'd3277;
   localparam logic [19:0] RST_POSE_KV          = 20'd102400;
   localparam logic [7:0]  RST_TICK_MS          = 8'd1;

   // Leg length held before the first request, 0.8 m in Q2.14.
   localparam logic [15:0] RST_LEG_PREV = 16'd13107;

   // Current configuration as seen by the front and back parts.
   typedef struct packed {
      logic [15:0] rest_length;
      logic [15:0] switch_length;
      logic [15:0] spring_stiffness;
      logic [19:0] thrust_force;
      logic [15:0] pose_kp;
      logic [19:0] pose_kv;
      logic [7:0]  tick_ms;
   } cfg_type;

   // One classified request, handed from the front part to the back part.
   typedef struct packed {
      logic [2:0]         phase;
      logic [1:0]         torque_mode;
      logic signed [16:0] spring_dx;
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [16:0] roll_rate;
      logic signed [16:0] pitch_rate;
      logic [15:0]        stance_ms;
   } entry_type;

endpackage

[rtl/hpc_front.sv]
// Front part: accepts requests, updates the tick state and classifies each request.
module hpc_front
   import hpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_fire,
   input  logic               req_foot_contact,
   input  logic [15:0]        req_leg_length,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   output entry_type          entry
);

   typedef enum logic [4:0] {
      ST_LOADING     = 5'b00001,
      ST_COMPRESSION = 5'b00010,
      ST_THRUST      = 5'b00100,
      ST_UNLOADING   = 5'b01000,
      ST_FLIGHT      = 5'b10000
   } hop_state_type;

   hop_state_type      state_ff, state_in;
   logic [31:0]        clock_ms_ff, clock_ms_in;
   logic [31:0]        stance_start_ff, stance_start_in;
   logic [15:0]        last_stance_ff, last_stance_in;
   logic               contact_prev_ff;
   logic [15:0]        leg_prev_ff;
   logic signed [16:0] leg_rate_ff, leg_rate_in;
   logic signed [15:0] roll_prev_ff, pitch_prev_ff;
   logic signed [16:0] roll_rate_ff, roll_rate_in;
   logic signed [16:0] pitch_rate_ff, pitch_rate_in;

   logic signed [16:0] leg_diff, roll_diff, pitch_diff;
   logic signed [17:0] leg_sum, roll_sum, pitch_sum;
   logic [31:0]        stance_gap;
   logic [2:0]         phase_code;
   logic [1:0]         mode_code;

   // Millisecond clock and filtered rates: rate = floor((rate + diff) / 2).
   always_comb begin
      clock_ms_in   = clock_ms_ff + {24'd0, cfg.tick_ms};
      leg_diff      = $signed({1'b0, req_leg_length}) - $signed({1'b0, leg_prev_ff});
      roll_diff     = {req_roll_angle[15], req_roll_angle} - {roll_prev_ff[15], roll_prev_ff};
      pitch_diff    = {req_pitch_angle[15], req_pitch_angle}
                      - {pitch_prev_ff[15], pitch_prev_ff};
      leg_sum       = {leg_rate_ff[16], leg_rate_ff} + {leg_diff[16], leg_diff};
      roll_sum      = {roll_rate_ff[16], roll_rate_ff} + {roll_diff[16], roll_diff};
      pitch_sum     = {pitch_rate_ff[16], pitch_rate_ff} + {pitch_diff[16], pitch_diff};
      leg_rate_in   = leg_sum[17:1];
      roll_rate_in  = roll_sum[17:1];
      pitch_rate_in = pitch_sum[17:1];
   end

   // Stance timing on the contact edges, duration saturated to 16 bits.
   always_comb begin
      stance_start_in = stance_start_ff;
      last_stance_in  = last_stance_ff;
      stance_gap      = clock_ms_in - stance_start_ff;
      if (!contact_prev_ff && req_foot_contact) begin
         stance_start_in = clock_ms_in;
      end
      if (contact_prev_ff && !req_foot_contact) begin
         last_stance_in = (|stance_gap[31:16]) ? 16'hFFFF : stance_gap[15:0];
      end
   end

   // Hop phase state machine, driven by this request's leg length, foot contact and new leg rate.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOADING: begin
            if (req_leg_length < cfg.switch_length) state_in = ST_COMPRESSION;
         end
         ST_COMPRESSION: begin
            if (leg_rate_in > 17'sd0) state_in = ST_THRUST;
         end
         ST_THRUST: begin
            if (req_leg_length > cfg.switch_length) state_in = ST_UNLOADING;
         end
         ST_UNLOADING: begin
            if (!req_foot_contact) state_in = ST_FLIGHT;
         end
         ST_FLIGHT: begin
            if (req_foot_contact) state_in = ST_LOADING;
         end
         default: begin
            state_in = ST_LOADING;
         end
      endcase
   end

   // Phase and torque mode codes of the new state.
   always_comb begin
      case (state_in)
         ST_LOADING: begin
            phase_code = PH_LOADING;
            mode_code  = MODE_ZERO;
         end
         ST_COMPRESSION: begin
            phase_code = PH_COMPRESSION;
            mode_code  = MODE_ATTITUDE;
         end
         ST_THRUST: begin
            phase_code = PH_THRUST;
            mode_code  = MODE_ATTITUDE;
         end
         ST_UNLOADING: begin
            phase_code = PH_UNLOADING;
            mode_code  = MODE_ZERO;
         end
         ST_FLIGHT: begin
            phase_code = PH_FLIGHT;
            mode_code  = MODE_FLIGHT;
         end
         default: begin
            phase_code = PH_LOADING;
            mode_code  = MODE_ZERO;
         end
      endcase
   end

   // Classified request written into the queue.
   always_comb begin
      entry.phase       = phase_code;
      entry.torque_mode = mode_code;
      entry.spring_dx   = $signed({1'b0, cfg.rest_length}) - $signed({1'b0, req_leg_length});
      entry.roll_angle  = req_roll_angle;
      entry.pitch_angle = req_pitch_angle;
      entry.roll_rate   = roll_rate_in;
      entry.pitch_rate  = pitch_rate_in;
      entry.stance_ms   = last_stance_in;
   end

   // Tick state, advanced once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOADING;
         clock_ms_ff     <= '0;
         stance_start_ff <= '0;
         last_stance_ff  <= '0;
         contact_prev_ff <= 1'b0;
         leg_prev_ff     <= RST_LEG_PREV;
         leg_rate_ff     <= '0;
         roll_prev_ff    <= '0;
         pitch_prev_ff   <= '0;
         roll_rate_ff    <= '0;
         pitch_rate_ff   <= '0;
      end else if (req_fire) begin
         state_ff        <= state_in;
         clock_ms_ff     <= clock_ms_in;
         stance_start_ff <= stance_start_in;
         last_stance_ff  <= last_stance_in;
         contact_prev_ff <= req_foot_contact;
         leg_prev_ff     <= req_leg_length;
         leg_rate_ff     <= leg_rate_in;
         roll_prev_ff    <= req_roll_angle;
         pitch_prev_ff   <= req_pitch_angle;
         roll_rate_ff    <= roll_rate_in;
         pitch_rate_ff   <= pitch_rate_in;
      end
   end

endmodule

[rtl/hpc_queue.sv]
// Short queue of classified requests between the front and back parts.
module hpc_queue
   import hpc_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_data
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   entry_type       slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Storage slots.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/hpc_back.sv]
// Back part: spring force and attitude torques on two shared multipliers, output register.
module hpc_back
   import hpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               head_valid,
   input  entry_type          head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_phase,
   output logic signed [27:0] rsp_spring_force,
   output logic signed [23:0] rsp_roll_torque,
   output logic signed [23:0] rsp_pitch_torque,
   output logic [1:0]         rsp_torque_mode,
   output logic [15:0]        rsp_stance_ms
);

   localparam logic [1:0] STEP_LAST = 2'd3;

   logic [1:0]         step_ff;
   logic               advance, out_free, last_step;
   logic signed [20:0] m0_a, m1_a;
   logic signed [16:0] m0_b, m1_b;
   logic signed [37:0] p0_ff, p1_ff, roll_acc_ff, pitch_acc_ff;
   logic signed [27:0] force_ff;
   logic signed [23:0] roll_tq_ff;
   logic signed [38:0] force_sum, roll_sum, pitch_sum;
   logic signed [26:0] roll_shift, pitch_shift;
   logic signed [27:0] force_sat;
   logic signed [23:0] roll_sat, pitch_sat;

   logic               rsp_valid_ff;
   logic [2:0]         phase_ff;
   logic signed [27:0] spring_force_ff;
   logic signed [23:0] roll_torque_ff, pitch_torque_ff;
   logic [1:0]         torque_mode_ff;
   logic [15:0]        stance_ms_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == STEP_LAST);
   assign advance   = head_valid && (!last_step || out_free);
   assign pop       = head_valid && last_step && out_free;

   // Operand selection for both multipliers per step.
   always_comb begin
      case (step_ff)
         2'd0: begin
            m0_a = $signed({5'd0, cfg.spring_stiffness});
            m0_b = head.spring_dx;
            m1_a = $signed({5'd0, cfg.pose_kp});
            m1_b = {head.roll_angle[15], head.roll_angle};
         end
         2'd1: begin
            m0_a = $signed({1'b0, cfg.pose_kv});
            m0_b = head.roll_rate;
            m1_a = $signed({5'd0, cfg.pose_kp});
            m1_b = {head.pitch_angle[15], head.pitch_angle};
         end
         default: begin
            m0_a = $signed({1'b0, cfg.pose_kv});
            m0_b = head.pitch_rate;
            m1_a = $signed({5'd0, cfg.pose_kp});
            m1_b = {head.pitch_angle[15], head.pitch_angle};
         end
      endcase
   end

   // Force: floor(product / 64) plus thrust in the thrust phase, saturated to 28 bits.
   always_comb begin
      force_sum = 39'(p0_ff >>> 6);
      if (head.phase == PH_THRUST) begin
         force_sum = force_sum + $signed({19'd0, cfg.thrust_force});
      end
      if (force_sum > 39'sd134217727) begin
         force_sat = 28'sh7FFFFFF;
      end else if (force_sum < -39'sd134217728) begin
         force_sat = -28'sh8000000;
      end else begin
         force_sat = force_sum[27:0];
      end
   end

   // Torques: floor((kp * angle + kv * rate) / 4096), saturated to 24 bits.
   always_comb begin
      roll_sum    = {roll_acc_ff[37], roll_acc_ff} + {p0_ff[37], p0_ff};
      pitch_sum   = {pitch_acc_ff[37], pitch_acc_ff} + {p0_ff[37], p0_ff};
      roll_shift  = roll_sum[38:12];
      pitch_shift = pitch_sum[38:12];
      if (roll_shift > 27'sd8388607) begin
         roll_sat = 24'sh7FFFFF;
      end else if (roll_shift < -27'sd8388608) begin
         roll_sat = -24'sh800000;
      end else begin
         roll_sat = roll_shift[23:0];
      end
      if (pitch_shift > 27'sd8388607) begin
         pitch_sat = 24'sh7FFFFF;
      end else if (pitch_shift < -27'sd8388608) begin
         pitch_sat = -24'sh800000;
      end else begin
         pitch_sat = pitch_shift[23:0];
      end
   end

   // Step counter of the back part.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (advance) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   // Product registers and partial results.
   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff <= 38'(m0_a * m0_b);
         p1_ff <= 38'(m1_a * m1_b);
         case (step_ff)
            2'd1: begin
               force_ff    <= force_sat;
               roll_acc_ff <= p1_ff;
            end
            2'd2: begin
               roll_tq_ff   <= roll_sat;
               pitch_acc_ff <= p1_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Output register; torques are forced to zero outside attitude hold.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         phase_ff        <= head.phase;
         spring_force_ff <= force_ff;
         torque_mode_ff  <= head.torque_mode;
         stance_ms_ff    <= head.stance_ms;
         if (head.torque_mode == MODE_ATTITUDE) begin
            roll_torque_ff  <= roll_tq_ff;
            pitch_torque_ff <= pitch_sat;
         end else begin
            roll_torque_ff  <= '0;
            pitch_torque_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phase        = phase_ff;
   assign rsp_spring_force = spring_force_ff;
   assign rsp_roll_torque  = roll_torque_ff;
   assign rsp_pitch_torque = pitch_torque_ff;
   assign rsp_torque_mode  = torque_mode_ff;
   assign rsp_stance_ms    = stance_ms_ff;

endmodule

[rtl/hopping_phase_controller.sv]
// A response is registered once its request has passed the queue and the back part, given a free output.
// The back part takes one request at a time through the four steps of the two shared multipliers.
// A request is accepted while the queue has room, also while a response waits to be taken.
// Reset (synchronous, active high) restores the configuration defaults, puts the hop phase
// in loading with clocks and rates cleared, and empties the queue and the output register.
module hopping_phase_controller
   import hpc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_foot_contact,
   input  logic [15:0]            req_leg_length,
   input  logic signed [15:0]     req_roll_angle,
   input  logic signed [15:0]     req_pitch_angle,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_phase,
   output logic signed [27:0]     rsp_spring_force,
   output logic signed [23:0]     rsp_roll_torque,
   output logic signed [23:0]     rsp_pitch_torque,
   output logic [1:0]             rsp_torque_mode,
   output logic [15:0]            rsp_stance_ms,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff;
   entry_type front_entry, head_entry;
   logic      queue_full, head_valid, head_pop, req_fire;

   assign req_ready = !queue_full;
   assign req_fire  = req_valid && req_ready;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_length      <= RST_REST_LENGTH;
         cfg_ff.switch_length    <= RST_SWITCH_LENGTH;
         cfg_ff.spring_stiffness <= RST_SPRING_STIFFNESS;
         cfg_ff.thrust_force     <= RST_THRUST_FORCE;
         cfg_ff.pose_kp          <= RST_POSE_KP;
         cfg_ff.pose_kv          <= RST_POSE_KV;
         cfg_ff.tick_ms          <= RST_TICK_MS;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_REST_LENGTH:      cfg_ff.rest_length      <= csr_wdata[15:0];
            CSR_SWITCH_LENGTH:    cfg_ff.switch_length    <= csr_wdata[15:0];
            CSR_SPRING_STIFFNESS: cfg_ff.spring_stiffness <= csr_wdata[15:0];
            CSR_THRUST_FORCE:     cfg_ff.thrust_force     <= csr_wdata[19:0];
            CSR_POSE_KP:          cfg_ff.pose_kp          <= csr_wdata[15:0];
            CSR_POSE_KV:          cfg_ff.pose_kv          <= csr_wdata[19:0];
            CSR_TICK_MS:          cfg_ff.tick_ms          <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Front part: tick state and classification.
   hpc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_fire         (req_fire),
      .req_foot_contact (req_foot_contact),
      .req_leg_length   (req_leg_length),
      .req_roll_angle   (req_roll_angle),
      .req_pitch_angle  (req_pitch_angle),
      .entry            (front_entry)
   );

   // Queue between the two parts.
   hpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (front_entry),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_data  (head_entry)
   );

   // Back part: force and torque arithmetic.
   hpc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head             (head_entry),
      .pop              (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_phase        (rsp_phase),
      .rsp_spring_force (rsp_spring_force),
      .rsp_roll_torque  (rsp_roll_torque),
      .rsp_pitch_torque (rsp_pitch_torque),
      .rsp_torque_mode  (rsp_torque_mode),
      .rsp_stance_ms    (rsp_stance_ms)
   );

endmodule

[tb/hopping_phase_controller_tb.sv]
// Self-checking testbench of the hopping phase controller: hop sequences, noise and CSR sweeps.
module hopping_phase_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hpc_pkg::*;

   // Index that no register decodes; writes to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int IDLE_LIMIT       = 2000;
   localparam int HOLD_AFTER_TICKS = 300;
   localparam int HOLD_CYCLES      = 200;
   localparam int PHASE_TICKS      = 190;
   localparam int LONG_HOLD_TICKS  = 262;

   // Ready patterns of the command receiver.
   localparam int READY_ALWAYS   = 0;
   localparam int READY_RANDOM   = 1;
   localparam int READY_MOSTLY   = 2;
   localparam int READY_PERIODIC = 3;

   // One command of the result channel.
   typedef struct {
      logic [2:0]         phase;
      logic signed [27:0] spring_force;
      logic signed [23:0] roll_torque;
      logic signed [23:0] pitch_torque;
      logic [1:0]         torque_mode;
      logic [15:0]        stance_ms;
   } hop_command_type;

   // Tracks the controller state per tick and keeps the commands still owed by the block.
   class hop_tracker_type;
      logic [15:0] rest_length, switch_length, spring_stiffness, pose_kp;
      logic [19:0] thrust_force, pose_kv;
      logic [7:0]  tick_ms;
      logic [2:0]  phase;
      logic [31:0] clock_ms, stance_start;
      logic [15:0] last_stance, leg_prev;
      logic        contact_prev;
      int          leg_rate;
      int          angle_prev[2];
      int          angle_rate[2];
      hop_command_type expected_commands[$];
      int          errors;

      function new();
         rest_length = RST_REST_LENGTH;
         switch_length = RST_SWITCH_LENGTH;
         spring_stiffness = RST_SPRING_STIFFNESS;
         thrust_force = RST_THRUST_FORCE;
         pose_kp = RST_POSE_KP;
         pose_kv = RST_POSE_KV;
         tick_ms = RST_TICK_MS;
         phase = PH_LOADING;
         clock_ms = '0;
         stance_start = '0;
         last_stance = '0;
         contact_prev = 1'b0;
         leg_prev = RST_LEG_PREV;
         leg_rate = 0;
         angle_prev = '{0, 0};
         angle_rate = '{0, 0};
         errors = 0;
      endfunction

      // Registers keep only as many bits as they are wide.
      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_REST_LENGTH:      rest_length = data[15:0];
            CSR_SWITCH_LENGTH:    switch_length = data[15:0];
            CSR_SPRING_STIFFNESS: spring_stiffness = data[15:0];
            CSR_THRUST_FORCE:     thrust_force = data[19:0];
            CSR_POSE_KP:          pose_kp = data[15:0];
            CSR_POSE_KV:          pose_kv = data[19:0];
            CSR_TICK_MS:          tick_ms = data[7:0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // Advances the controller by one accepted request and queues the command it yields.
      function void note_tick(logic contact, logic [15:0] leg, logic signed [15:0] roll,
                              logic signed [15:0] pitch);
         int          angle[2];
         longint      spring;
         longint      acc;
         longint      torque[2];
         logic [31:0] held;
         hop_command_type cmd;
         angle[0] = int'(roll);
         angle[1] = int'(pitch);
         clock_ms = clock_ms + {24'd0, tick_ms};

         // Filtered rates: half the sum of the old rate and the new difference, rounded down.
         leg_rate = (leg_rate + int'(leg) - int'(leg_prev)) >>> 1;
         leg_prev = leg;
         for (int i = 0; i < 2; i++) begin
            angle_rate[i] = (angle_rate[i] + angle[i] - angle_prev[i]) >>> 1;
            angle_prev[i] = angle[i];
         end

         // Stance timing on the contact edges, saturated to 16 bits.
         if (!contact_prev && contact) stance_start = clock_ms;
         if (contact_prev && !contact) begin
            held = clock_ms - stance_start;
            last_stance = (held > 32'd65535) ? 16'hFFFF : held[15:0];
         end
         contact_prev = contact;

         case (phase)
            PH_LOADING:     if (leg < switch_length) phase = PH_COMPRESSION;
            PH_COMPRESSION: if (leg_rate > 0) phase = PH_THRUST;
            PH_THRUST:      if (leg > switch_length) phase = PH_UNLOADING;
            PH_UNLOADING:   if (!contact) phase = PH_FLIGHT;
            PH_FLIGHT:      if (contact) phase = PH_LOADING;
            default: ;
         endcase

         spring = ((longint'(rest_length) - longint'(leg)) * longint'(spring_stiffness)) >>> 6;
         if (phase == PH_THRUST) spring = spring + longint'(thrust_force);
         spring = clamp(spring, -134217728, 134217727);

         // Attitude hold only while the leg is compressing or thrusting.
         torque = '{0, 0};
         if (phase == PH_COMPRESSION || phase == PH_THRUST) begin
            cmd.torque_mode = MODE_ATTITUDE;
            for (int i = 0; i < 2; i++) begin
               acc = longint'(pose_kp) * longint'(angle[i])
                     + longint'(pose_kv) * longint'(angle_rate[i]);
               torque[i] = clamp(acc >>> 12, -8388608, 8388607);
            end
         end else if (phase == PH_FLIGHT) begin
            cmd.torque_mode = MODE_FLIGHT;
         end else begin
            cmd.torque_mode = MODE_ZERO;
         end

         cmd.phase = phase;
         cmd.spring_force = 28'(spring);
         cmd.roll_torque = 24'(torque[0]);
         cmd.pitch_torque = 24'(torque[1]);
         cmd.stance_ms = last_stance;
         expected_commands.push_back(cmd);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (got != want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_command(hop_command_type got);
         hop_command_type want;
         if (expected_commands.size() == 0) begin
            errors++;
            $display("%0t: unexpected command, expected none, actual phase %0d force %0d",
                     $time, got.phase, got.spring_force);
         end else begin
            want = expected_commands.pop_front();
            compare_field("phase", longint'(want.phase), longint'(got.phase));
            compare_field("spring_force", longint'(want.spring_force),
                          longint'(got.spring_force));
            compare_field("roll_torque", longint'(want.roll_torque),
                          longint'(got.roll_torque));
            compare_field("pitch_torque", longint'(want.pitch_torque),
                          longint'(got.pitch_torque));
            compare_field("torque_mode", longint'(want.torque_mode),
                          longint'(got.torque_mode));
            compare_field("stance_ms", longint'(want.stance_ms), longint'(got.stance_ms));
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_foot_contact = 1'b0;
   logic [15:0]            req_leg_length = '0;
   logic signed [15:0]     req_roll_angle = '0;
   logic signed [15:0]     req_pitch_angle = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_phase;
   logic signed [27:0]     rsp_spring_force;
   logic signed [23:0]     rsp_roll_torque;
   logic signed [23:0]     rsp_pitch_torque;
   logic [1:0]             rsp_torque_mode;
   logic [15:0]            rsp_stance_ms;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   hop_tracker_type    tracker;
   int                 ticks_sent = 0;
   int                 burst_left = 0;
   bit                 sender_idle = 1'b1;
   int                 ready_pattern = READY_RANDOM;
   logic               rsp_hold = 1'b0;
   int unsigned        stall_tick = 0;
   int                 idle_cycles = 0;
   logic signed [15:0] roll_now = '0;
   logic signed [15:0] pitch_now = '0;

   hopping_phase_controller uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_foot_contact (req_foot_contact),
      .req_leg_length   (req_leg_length),
      .req_roll_angle   (req_roll_angle),
      .req_pitch_angle  (req_pitch_angle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_phase        (rsp_phase),
      .rsp_spring_force (rsp_spring_force),
      .rsp_roll_torque  (rsp_roll_torque),
      .rsp_pitch_torque (rsp_pitch_torque),
      .rsp_torque_mode  (rsp_torque_mode),
      .rsp_stance_ms    (rsp_stance_ms),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Receiver ready follows the pattern chosen for the current phase.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         case (ready_pattern)
            READY_ALWAYS:   rsp_ready <= 1'b1;
            READY_RANDOM:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
            default:        rsp_ready <= ((stall_tick % 7) < 3);
         endcase
      end
   end

   // One long receiver stall while requests keep coming, so the input side backs up.
   initial begin
      wait (ticks_sent >= HOLD_AFTER_TICKS);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Every accepted command is checked against the oldest one owed.
   always @(posedge clock) begin : command_monitor
      hop_command_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.phase = rsp_phase;
         seen.spring_force = rsp_spring_force;
         seen.roll_torque = rsp_roll_torque;
         seen.pitch_torque = rsp_pitch_torque;
         seen.torque_mode = rsp_torque_mode;
         seen.stance_ms = rsp_stance_ms;
         tracker.check_command(seen);
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Offers one tick request, waits for its acceptance, then maybe pauses between bursts.
   task automatic offer_tick(input logic contact, input logic [15:0] leg,
                             input logic signed [15:0] roll, input logic signed [15:0] pitch);
      int gap;
      req_valid <= 1'b1;
      req_foot_contact <= contact;
      req_leg_length <= leg;
      req_roll_angle <= roll;
      req_pitch_angle <= pitch;
      do @(posedge clock); while (!req_ready);
      tracker.note_tick(contact, leg, roll, pitch);
      ticks_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = sender_idle ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // A tick of a hop: the angles drift, with an occasional jump anywhere in range.
   task automatic hop_tick(input logic contact, input int leg);
      int r;
      int p;
      if ($urandom_range(0, 15) == 0) begin
         roll_now = 16'($urandom);
         pitch_now = 16'($urandom);
      end else begin
         r = int'(roll_now) + int'($urandom_range(0, 600)) - 300;
         p = int'(pitch_now) + int'($urandom_range(0, 600)) - 300;
         roll_now = 16'((r > 32767) ? 32767 : ((r < -32768) ? -32768 : r));
         pitch_now = 16'((p > 32767) ? 32767 : ((p < -32768) ? -32768 : p));
      end
      leg = leg + int'($urandom_range(0, 16)) - 8;
      leg = (leg > 65535) ? 65535 : ((leg < 0) ? 0 : leg);
      offer_tick(contact, 16'(leg), roll_now, pitch_now);
   endtask

   // A well-formed hop around the current threshold: touchdown, compression, thrust, flight.
   task automatic run_hop(input bit long_stance);
      int sw, top, bottom, down_n, up_n, hold_n, flight_n;
      sw = int'(tracker.switch_length);
      top = sw + int'($urandom_range(200, 3000));
      if (top > 65535) top = 65535;
      bottom = sw - int'($urandom_range(200, 4000));
      if (bottom < 0) bottom = 0;
      down_n = $urandom_range(2, 10);
      up_n = $urandom_range(2, 10);
      hold_n = long_stance ? LONG_HOLD_TICKS : $urandom_range(0, 3);
      flight_n = $urandom_range(1, 8);
      for (int k = 0; k < down_n; k++) hop_tick(1'b1, top - (top - bottom) * k / down_n);
      for (int k = 0; k < hold_n; k++) hop_tick(1'b1, bottom);
      for (int k = 1; k <= up_n; k++) hop_tick(1'b1, bottom + (top - bottom) * k / up_n);
      hop_tick(1'b1, top + 200);
      for (int k = 0; k < flight_n; k++) hop_tick(1'b0, top);
   endtask

   // Stops offering and waits until every owed command has arrived.
   task automatic drain_commands();
      if (req_valid) req_valid <= 1'b0;
      while (tracker.expected_commands.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   // Writes every register, plus one write to an index nothing decodes.
   task automatic program_settings(input logic [19:0] rest, input logic [19:0] threshold,
                                   input logic [19:0] stiffness, input logic [19:0] thrust,
                                   input logic [19:0] kp, input logic [19:0] kv,
                                   input logic [19:0] tick);
      csr_write(CSR_REST_LENGTH, rest);
      csr_write(CSR_SWITCH_LENGTH, threshold);
      csr_write(CSR_SPRING_STIFFNESS, stiffness);
      csr_write(CSR_THRUST_FORCE, thrust);
      csr_write(CSR_POSE_KP, kp);
      csr_write(CSR_POSE_KV, kv);
      csr_write(CSR_TICK_MS, tick);
      csr_write(CSR_UNUSED_INDEX, 20'($urandom));
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly hops with random content, some pure noise, then a full drain.
   task automatic run_phase(input int count, input bit long_first);
      int start;
      start = ticks_sent;
      if (long_first) run_hop(1'b1);
      while (ticks_sent - start < count) begin
         if ($urandom_range(0, 4) != 0) begin
            run_hop($urandom_range(0, 99) == 0);
         end else begin
            repeat ($urandom_range(1, 6))
               offer_tick(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                          16'($urandom));
         end
      end
      drain_commands();
   endtask

   initial begin
      tracker = new();
      wait (!reset);
      @(posedge clock);

      // Directed: a full hop at reset settings with extreme legs and angles, threshold edges,
      // contact lost outside flight and a loading phase that never compresses.
      offer_tick(1'b1, 16'd16000, 16'sd0, 16'sd0);
      offer_tick(1'b1, 16'd0, -16'sd32768, 16'sd32767);
      offer_tick(1'b1, 16'd0, 16'sd32767, -16'sd32768);
      offer_tick(1'b1, 16'd10000, 16'sd0, 16'sd0);
      offer_tick(1'b1, 16'd14000, 16'sd100, -16'sd100);
      offer_tick(1'b1, 16'd65535, 16'sd32767, 16'sd32767);
      offer_tick(1'b1, 16'd65535, -16'sd32768, -16'sd32768);
      offer_tick(1'b0, 16'd65535, 16'sd0, 16'sd0);
      offer_tick(1'b0, 16'd0, 16'sd32767, -16'sd32768);
      offer_tick(1'b0, 16'd30000, -16'sd1, 16'sd1);
      offer_tick(1'b1, 16'd16384, 16'sd0, 16'sd0);
      offer_tick(1'b1, 16'd14746, 16'sd0, 16'sd0);
      offer_tick(1'b1, 16'd14745, 16'sd5, 16'sd5);
      offer_tick(1'b1, 16'd14745, 16'sd10, -16'sd10);
      offer_tick(1'b1, 16'd14746, 16'sd20, -16'sd20);
      offer_tick(1'b1, 16'd20000, 16'sd0, 16'sd0);
      offer_tick(1'b1, 16'd14746, 16'sd0, 16'sd0);
      offer_tick(1'b1, 16'd14747, 16'sd0, 16'sd0);
      offer_tick(1'b0, 16'd16384, 16'sd0, 16'sd0);
      offer_tick(1'b1, 16'd16384, 16'sd0, 16'sd0);
      offer_tick(1'b0, 16'd16384, 16'sd0, 16'sd0);
      offer_tick(1'b1, 16'd0, 16'sd1000, 16'sd2000);
      offer_tick(1'b0, 16'd0, -16'sd1000, -16'sd2000);
      drain_commands();

      // Plausible random settings.
      ready_pattern = READY_RANDOM;
      sender_idle = 1'b1;
      program_settings(20'($urandom_range(14000, 20000)), 20'($urandom_range(12000, 16000)),
                       20'($urandom_range(0, 65535)), 20'($urandom_range(0, 1048575)),
                       20'($urandom_range(0, 65535)), 20'($urandom_range(0, 1048575)),
                       20'($urandom_range(1, 5)));
      run_phase(PHASE_TICKS, 1'b0);

      // Every register at its maximum; no idling on either side.
      ready_pattern = READY_ALWAYS;
      sender_idle = 1'b0;
      program_settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                       20'hFFFFF);
      run_phase(PHASE_TICKS, 1'b1);

      // Every register at zero: the clock stands still.
      ready_pattern = READY_MOSTLY;
      sender_idle = 1'b1;
      program_settings('0, '0, '0, '0, '0, '0, '0);
      run_phase(PHASE_TICKS, 1'b0);

      // Slow clock and large gains: stance time and torques saturate.
      ready_pattern = READY_PERIODIC;
      program_settings(20'(RST_REST_LENGTH), 20'(RST_SWITCH_LENGTH), 20'hFFFF, 20'hFFFFF,
                       20'hFFFF, 20'hFFFFF, 20'd255);
      run_phase(PHASE_TICKS, 1'b1);

      // Fully random data words, upper bits dropped by the narrower registers.
      ready_pattern = READY_RANDOM;
      program_settings(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                       20'($urandom), 20'($urandom), 20'($urandom));
      run_phase(PHASE_TICKS, 1'b0);

      // Back to the reset values.
      ready_pattern = READY_MOSTLY;
      program_settings(20'(RST_REST_LENGTH), 20'(RST_SWITCH_LENGTH),
                       20'(RST_SPRING_STIFFNESS), RST_THRUST_FORCE, 20'(RST_POSE_KP),
                       RST_POSE_KV, 20'(RST_TICK_MS));
      run_phase(PHASE_TICKS, 1'b0);

      if (tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
